[hdl/chcb_pkg.sv]
// shared types, constants and helpers for the canonical huffman code builder
package chcb_pkg;

	// sizes
	localparam int MAX_SYMBOLS = 288;
	localparam int LENGTH_LIMIT = 15;
	localparam int SYM_W = $clog2(MAX_SYMBOLS);
	localparam int SYM_CNT_W = $clog2(MAX_SYMBOLS + 1);
	localparam int SYM_IDX_W = 9;
	localparam int LEN_W = 4;
	localparam int CODE_W = 15;
	localparam int HIST_W = SYM_CNT_W;
	localparam int ROOM_W = CODE_W + 3;
	localparam int NUM_LENGTHS = 16;

	// action codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// result kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_CODE = 1'b1;

	// build status codes
	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_TOO_LONG = 2'd1;
	localparam logic [1:0] STAT_NO_SYMBOLS = 2'd2;
	localparam logic [1:0] STAT_OVERSUB = 2'd3;

	// register indexes
	localparam logic [1:0] REG_MAX_BIT_LENGTH = 2'd0;
	localparam logic [1:0] REG_REQUIRE_SYMBOLS = 2'd1;
	localparam logic [1:0] REG_LSB_FIRST = 2'd2;

	// write side of the symbol store
	typedef struct packed {
		logic len_we;
		logic [SYM_W-1:0] len_addr;
		logic [LEN_W-1:0] len_data;
		logic code_we;
		logic [SYM_W-1:0] code_addr;
		logic [CODE_W-1:0] code_data;
	} store_wr_t;

	// reverse the low len bits of a code
	function automatic logic [CODE_W-1:0] rev_code(input logic [CODE_W-1:0] c,
			input logic [LEN_W-1:0] len);
		logic [CODE_W-1:0] r;
		for (int i = 0; i < CODE_W; i++) begin
			r[i] = c[CODE_W-1-i];
		end
		return r >> (LEN_W'(CODE_W) - len);
	endfunction

endpackage

[hdl/chcb_symbol_store.sv]
// per-symbol length and code memories with registered read
module chcb_symbol_store import chcb_pkg::*; (
	input logic clk,
	input store_wr_t wr,
	input logic [SYM_W-1:0] rd_addr,
	output logic [LEN_W-1:0] len_rd,
	output logic [CODE_W-1:0] code_rd
);

	logic [LEN_W-1:0] len_mem [MAX_SYMBOLS];
	logic [CODE_W-1:0] code_mem [MAX_SYMBOLS];

	// length memory
	always_ff @(posedge clk) begin
		if (wr.len_we) begin
			len_mem[wr.len_addr] <= wr.len_data;
		end
		len_rd <= len_mem[rd_addr];
	end

	// code memory
	always_ff @(posedge clk) begin
		if (wr.code_we) begin
			code_mem[wr.code_addr] <= wr.code_data;
		end
		code_rd <= code_mem[rd_addr];
	end

endmodule

[hdl/canonical_huffman_code_builder_unit.sv]
// canonical huffman code builder: length loading, kraft check, code assignment, readout
//
//  channel   | ports                                           | transaction
//  ----------+-------------------------------------------------+-----------------------------
//  command   | start, busy, action, code_length, last_length,  | start && !busy
//            | symbol_index                                    |
//  result    | result_valid, result_kind, status,              | result_valid (one cycle)
//            | longest_used, stored_code, stored_length        |
//  config    | psel, penable, pwrite, paddr, pwdata, prdata,   | psel && penable && pwrite
//            | pready                                          |
//
// a length load without last mark leaves busy low
// a read is a memory read, then the result in ST_READ
// a build runs ST_CHECK, the kraft walk over bit lengths, the symbol walk through the one read
// port of the length memory, then the ST_DONE result; too-long and empty-set errors skip both walks,
// oversubscription skips the symbol walk; reset clears all control state and the histogram;
// the memories hold garbage until a build; results are strobed for one cycle and cannot be stalled
module canonical_huffman_code_builder_unit import chcb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic start,
	output logic busy,
	input logic action,
	input logic [LEN_W-1:0] code_length,
	input logic last_length,
	input logic [SYM_IDX_W-1:0] symbol_index,
	output logic result_valid,
	output logic result_kind,
	output logic [1:0] status,
	output logic [LEN_W-1:0] longest_used,
	output logic [CODE_W-1:0] stored_code,
	output logic [LEN_W-1:0] stored_length
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_READ = 6'b000010,
		ST_CHECK = 6'b000100,
		ST_KRAFT = 6'b001000,
		ST_WALK = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q;

	// configuration
	logic [LEN_W-1:0] max_q;
	logic req_q;
	logic lsb_q;

	// set in progress
	logic [SYM_CNT_W-1:0] loaded_q;
	logic too_long_q;
	logic [LEN_W-1:0] run_longest_q;
	logic [HIST_W-1:0] hist_q [NUM_LENGTHS];

	// last build
	logic [1:0] err_q;
	logic [LEN_W-1:0] longest_q;
	logic rd_ok_q;

	// kraft walk
	logic [LEN_W-1:0] b_q;
	logic signed [ROOM_W-1:0] room_q;
	logic [CODE_W-1:0] acc_q;
	logic [HIST_W-1:0] hist_prev_q;
	logic [CODE_W-1:0] next_code_q [NUM_LENGTHS];

	// symbol walk
	logic [SYM_CNT_W-1:0] s_q;
	logic v_s1;
	logic [SYM_W-1:0] s_s1;

	store_wr_t wr;
	logic [SYM_W-1:0] rd_addr;
	logic [LEN_W-1:0] len_rd;
	logic [CODE_W-1:0] code_rd;

	logic accept;
	logic load_acc;
	logic load_room;
	logic sym_in_range;
	logic cfg_wr;
	logic [HIST_W-1:0] hist_b;
	logic [CODE_W-1:0] acc_next;
	logic signed [ROOM_W-1:0] room_next;
	logic issue;
	logic in_set;
	logic assign_code;
	logic [CODE_W-1:0] nc;
	logic [CODE_W-1:0] coded;

	assign pready = 1'b1;
	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign load_acc = accept && (action == ACT_LOAD);
	assign load_room = loaded_q < SYM_CNT_W'(MAX_SYMBOLS);
	assign sym_in_range = 32'(symbol_index) < MAX_SYMBOLS;
	assign cfg_wr = psel && penable && pwrite && pready;

	// kraft step: separate adders for remaining room and first codes
	assign hist_b = hist_q[b_q];
	assign acc_next = (acc_q + CODE_W'(hist_prev_q)) << 1;
	assign room_next = (room_q <<< 1) - ROOM_W'(hist_b);

	// symbol walk step
	assign issue = (s_q != SYM_CNT_W'(MAX_SYMBOLS));
	assign in_set = SYM_CNT_W'(s_s1) < loaded_q;
	assign assign_code = in_set && (len_rd != '0);
	assign nc = next_code_q[len_rd];
	assign coded = lsb_q ? rev_code(nc, len_rd) : nc;

	// store ports
	always_comb begin
		wr = '0;
		if (load_acc && load_room) begin
			wr.len_we = 1'b1;
			wr.len_addr = loaded_q[SYM_W-1:0];
			wr.len_data = code_length;
		end
		if ((state_q == ST_WALK) && v_s1) begin
			wr.code_we = 1'b1;
			wr.code_addr = s_s1;
			wr.code_data = assign_code ? coded : '0;
			if (!in_set) begin
				wr.len_we = 1'b1;
				wr.len_addr = s_s1;
				wr.len_data = '0;
			end
		end
		if (state_q == ST_WALK) begin
			rd_addr = s_q[SYM_W-1:0];
		end else if (sym_in_range) begin
			rd_addr = symbol_index[SYM_W-1:0];
		end else begin
			rd_addr = '0;
		end
	end

	chcb_symbol_store u_store (
		.clk (clk),
		.wr (wr),
		.rd_addr (rd_addr),
		.len_rd (len_rd),
		.code_rd (code_rd)
	);

	// register readback
	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_MAX_BIT_LENGTH: prdata = 32'(max_q);
			REG_REQUIRE_SYMBOLS: prdata = 32'(req_q);
			REG_LSB_FIRST: prdata = 32'(lsb_q);
			default: prdata = '0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= LEN_W'(LENGTH_LIMIT);
			req_q <= 1'b1;
			lsb_q <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MAX_BIT_LENGTH: max_q <= pwdata[LEN_W-1:0];
				REG_REQUIRE_SYMBOLS: req_q <= pwdata[0];
				REG_LSB_FIRST: lsb_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// sequencer and set state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			loaded_q <= '0;
			too_long_q <= 1'b0;
			run_longest_q <= '0;
			for (int i = 0; i < NUM_LENGTHS; i++) begin
				hist_q[i] <= '0;
			end
			err_q <= STAT_OK;
			longest_q <= '0;
			rd_ok_q <= 1'b0;
			b_q <= '0;
			room_q <= '0;
			acc_q <= '0;
			hist_prev_q <= '0;
			s_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (action == ACT_READ)) begin
						rd_ok_q <= sym_in_range && (err_q == STAT_OK);
						state_q <= ST_READ;
					end else if (load_acc) begin
						if (load_room) begin
							loaded_q <= loaded_q + 1'b1;
							if (code_length > max_q) begin
								too_long_q <= 1'b1;
							end
							if (code_length != '0) begin
								hist_q[code_length] <= hist_q[code_length] + 1'b1;
								if (code_length > run_longest_q) begin
									run_longest_q <= code_length;
								end
							end
						end
						if (last_length) begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				// precedence: too long, then empty set, then kraft
				ST_CHECK: begin
					longest_q <= run_longest_q;
					b_q <= LEN_W'(1);
					room_q <= ROOM_W'(1);
					acc_q <= '0;
					hist_prev_q <= '0;
					s_q <= '0;
					v_s1 <= 1'b0;
					if (too_long_q) begin
						err_q <= STAT_TOO_LONG;
						state_q <= ST_DONE;
					end else if (run_longest_q == '0) begin
						if (req_q) begin
							err_q <= STAT_NO_SYMBOLS;
							state_q <= ST_DONE;
						end else begin
							err_q <= STAT_OK;
							state_q <= ST_WALK;
						end
					end else begin
						err_q <= STAT_OK;
						state_q <= ST_KRAFT;
					end
				end
				// one bit length per cycle
				ST_KRAFT: begin
					acc_q <= acc_next;
					hist_prev_q <= hist_b;
					if (b_q <= max_q) begin
						room_q <= room_next;
					end
					if ((b_q <= max_q) && (room_next < 0)) begin
						err_q <= STAT_OVERSUB;
						state_q <= ST_DONE;
					end else if (b_q == LEN_W'(LENGTH_LIMIT)) begin
						state_q <= ST_WALK;
					end else begin
						b_q <= b_q + 1'b1;
					end
				end
				// one symbol per cycle, read then assign
				ST_WALK: begin
					v_s1 <= issue;
					if (issue) begin
						s_q <= s_q + 1'b1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					loaded_q <= '0;
					too_long_q <= 1'b0;
					run_longest_q <= '0;
					for (int i = 0; i < NUM_LENGTHS; i++) begin
						hist_q[i] <= '0;
					end
					v_s1 <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// first codes and walk payload
	always_ff @(posedge clk) begin
		if (state_q == ST_KRAFT) begin
			next_code_q[b_q] <= acc_next;
		end
		if ((state_q == ST_WALK) && v_s1 && assign_code) begin
			next_code_q[len_rd] <= nc + 1'b1;
		end
		s_s1 <= s_q[SYM_W-1:0];
	end

	// result ports
	assign result_valid = (state_q == ST_READ) || (state_q == ST_DONE);
	assign result_kind = (state_q == ST_READ) ? KIND_CODE : KIND_STATUS;
	assign status = err_q;
	assign longest_used = longest_q;
	assign stored_code = ((state_q == ST_READ) && rd_ok_q) ? code_rd : '0;
	assign stored_length = ((state_q == ST_READ) && rd_ok_q) ? len_rd : '0;

	// checks
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_read_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == ACT_READ)) |=> (result_valid && (result_kind == KIND_CODE)))
		else $error("read transaction without code result");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == ACT_LOAD) && !last_length) |=> (!result_valid && !busy))
		else $error("plain length load produced a result or stalled");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= SYM_CNT_W'(MAX_SYMBOLS))
		else $error("loaded count beyond symbol limit");

endmodule
